@@ hw/rtl/encoder_tuned_strobe_generator_assert.svh @@
// Assertion macros shared by the strobe generator RTL.
`ifndef ENCODER_TUNED_STROBE_GENERATOR_ASSERT_SVH
`define ENCODER_TUNED_STROBE_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ETSG_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define ETSG_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/etsg_pkg.sv @@
// Shared types, constants and the encoder decode function.
`default_nettype none

package etsg_pkg;

   localparam int FREQ_W   = 6;
   localparam int TPS_W    = 16;
   localparam int PERIOD_W = 16;
   localparam int ON_W     = 14;
   localparam int REM_W    = 6;

   localparam logic [FREQ_W-1:0]   MAX_FREQUENCY = 6'd32;
   localparam logic [TPS_W-1:0]    TPS_RESET     = 16'd1000;
   localparam logic [FREQ_W-1:0]   FREQ_RESET    = 6'd1;
   localparam logic [ON_W-1:0]     ON_RESET      = 14'd250;
   localparam logic [PERIOD_W-1:0] OFF_RESET     = 16'd750;

   // one restoring step per quotient bit
   localparam int DIV_STEPS = PERIOD_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   localparam logic ACTION_ENCODER = 1'b0;
   localparam logic ACTION_TICK    = 1'b1;

   typedef enum logic [1:0] {
      STEP_NONE,
      STEP_UP,
      STEP_DOWN
   } step_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic div_step;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic recompute;
   } status_type;

   // quadrature transition decode: {previous pair, current pair}
   function automatic step_type decode_step(input logic [3:0] sum);
      step_type step;
      case (sum) inside
         4'hD, 4'h4, 4'h2, 4'hB: step = STEP_UP;
         4'hE, 4'h7, 4'h1, 4'h8: step = STEP_DOWN;
         default:                step = STEP_NONE;
      endcase
      return step;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/etsg_dp.sv @@
// Datapath: frequency, phase state, serial period divider and result register.
`default_nettype none

module etsg_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_action,
   input  wire logic                          req_enc_a,
   input  wire logic                          req_enc_b,
   input  wire logic                          csr_wr_en,
   input  wire logic [etsg_pkg::TPS_W-1:0]    csr_wr_data,
   input  wire etsg_pkg::cmd_type             cmd,
   output etsg_pkg::status_type               status,
   output logic                               rsp_led_on,
   output logic [etsg_pkg::FREQ_W-1:0]        rsp_frequency,
   output logic [etsg_pkg::ON_W-1:0]          rsp_on_ticks,
   output logic [etsg_pkg::PERIOD_W-1:0]      rsp_off_ticks
);

   logic [etsg_pkg::TPS_W-1:0]    tps_ff, tps_in;
   logic [1:0]                    prev_pair_ff, prev_pair_in;
   logic [etsg_pkg::FREQ_W-1:0]   freq_ff, freq_in;
   logic [etsg_pkg::ON_W-1:0]     on_len_ff, on_len_in;
   logic [etsg_pkg::PERIOD_W-1:0] off_len_ff, off_len_in;
   logic [etsg_pkg::PERIOD_W-1:0] phase_ff, phase_in;
   logic                          off_phase_ff, off_phase_in;
   logic                          recompute_ff, recompute_in;
   logic                          action_ff, action_in;
   logic [etsg_pkg::FREQ_W-1:0]   divisor_ff, divisor_in;
   logic [etsg_pkg::PERIOD_W-1:0] quot_ff, quot_in;
   logic [etsg_pkg::REM_W-1:0]    rem_ff, rem_in;
   logic                          led_ff, led_in;
   logic [etsg_pkg::FREQ_W-1:0]   out_freq_ff, out_freq_in;
   logic [etsg_pkg::ON_W-1:0]     out_on_ff, out_on_in;
   logic [etsg_pkg::PERIOD_W-1:0] out_off_ff, out_off_in;

   logic [1:0]                    pair;
   etsg_pkg::step_type            step;
   logic                          in_range;
   logic [etsg_pkg::FREQ_W-1:0]   freq_next;
   logic [etsg_pkg::REM_W:0]      shifted;
   logic [etsg_pkg::REM_W+1:0]    trial;
   logic                          borrow;
   logic [etsg_pkg::PERIOD_W-1:0] period;
   logic [etsg_pkg::ON_W-1:0]     on_calc;
   logic [etsg_pkg::PERIOD_W-1:0] off_calc;
   logic [etsg_pkg::PERIOD_W-1:0] on_len16;
   logic [etsg_pkg::PERIOD_W-1:0] tick_pc;
   logic                          tick_off;
   logic                          tick_active;
   logic                          tick_led;
   logic                          enc_led;

   // decode the sample against the stored pair and range-check the step
   assign pair = {req_enc_a, req_enc_b};
   assign step = etsg_pkg::decode_step({prev_pair_ff, pair});

   always_comb begin
      case (step)
         etsg_pkg::STEP_UP: begin
            in_range  = (freq_ff < etsg_pkg::MAX_FREQUENCY);
            freq_next = freq_ff + 1'b1;
         end
         etsg_pkg::STEP_DOWN: begin
            in_range  = (freq_ff != '0);
            freq_next = freq_ff - 1'b1;
         end
         default: begin
            in_range  = 1'b1;
            freq_next = freq_ff;
         end
      endcase
   end

   assign status.recompute = (req_action == etsg_pkg::ACTION_ENCODER) && in_range;

   // one restoring division step
   assign shifted = {rem_ff, quot_ff[etsg_pkg::PERIOD_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, divisor_ff};
   assign borrow  = trial[etsg_pkg::REM_W+1];

   // split the period into on and off lengths
   assign period   = (divisor_ff == '0) ? '0 : quot_ff;
   assign on_calc  = period[etsg_pkg::PERIOD_W-1:2];
   assign off_calc = period - {2'b00, on_calc};
   assign on_len16 = {2'b00, on_len_ff};

   // advance the on/off phase sequence by one tick
   always_comb begin
      tick_pc     = phase_ff;
      tick_off    = off_phase_ff;
      tick_active = 1'b1;
      tick_led    = 1'b0;
      if (tick_pc == '0) begin
         tick_pc = tick_off ? off_len_ff : on_len16;
         if (tick_pc == '0) begin
            tick_off = !tick_off;
            tick_pc  = tick_off ? off_len_ff : on_len16;
         end
         if (tick_pc == '0) begin
            tick_off    = 1'b0;
            tick_active = 1'b0;
         end
      end
      if (tick_active) begin
         tick_led = !tick_off;
         tick_pc  = tick_pc - 1'b1;
         if (tick_pc == '0) begin
            tick_off = !tick_off;
         end
      end
   end

   assign enc_led = !off_phase_ff && (phase_ff != '0);

   // next-state selection
   always_comb begin
      tps_in       = csr_wr_en ? csr_wr_data : tps_ff;
      prev_pair_in = prev_pair_ff;
      freq_in      = freq_ff;
      on_len_in    = on_len_ff;
      off_len_in   = off_len_ff;
      phase_in     = phase_ff;
      off_phase_in = off_phase_ff;
      recompute_in = recompute_ff;
      action_in    = action_ff;
      divisor_in   = divisor_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      led_in       = led_ff;
      out_freq_in  = out_freq_ff;
      out_on_in    = out_on_ff;
      out_off_in   = out_off_ff;

      // take the item: step the frequency on an in-range encoder sample and load the divider
      if (cmd.accept) begin
         action_in    = req_action;
         recompute_in = status.recompute;
         divisor_in   = freq_next;
         quot_in      = tps_ff;
         rem_in       = '0;
         if (req_action == etsg_pkg::ACTION_ENCODER) begin
            prev_pair_in = pair;
            if (in_range) begin
               freq_in = freq_next;
            end
         end
      end

      // shift one quotient bit in
      if (cmd.div_step) begin
         rem_in  = borrow ? shifted[etsg_pkg::REM_W-1:0] : trial[etsg_pkg::REM_W-1:0];
         quot_in = {quot_ff[etsg_pkg::PERIOD_W-2:0], !borrow};
      end

      // commit the item and load the result register
      if (cmd.finish) begin
         out_freq_in = freq_ff;
         out_on_in   = on_len_ff;
         out_off_in  = off_len_ff;
         if (action_ff == etsg_pkg::ACTION_TICK) begin
            phase_in     = tick_pc;
            off_phase_in = tick_off;
            led_in       = tick_led;
         end else begin
            led_in = enc_led;
            if (recompute_ff) begin
               on_len_in  = on_calc;
               off_len_in = off_calc;
               out_on_in  = on_calc;
               out_off_in = off_calc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff       <= etsg_pkg::TPS_RESET;
         prev_pair_ff <= '0;
         freq_ff      <= etsg_pkg::FREQ_RESET;
         on_len_ff    <= etsg_pkg::ON_RESET;
         off_len_ff   <= etsg_pkg::OFF_RESET;
         phase_ff     <= '0;
         off_phase_ff <= 1'b0;
         recompute_ff <= 1'b0;
         action_ff    <= etsg_pkg::ACTION_ENCODER;
      end else begin
         tps_ff       <= tps_in;
         prev_pair_ff <= prev_pair_in;
         freq_ff      <= freq_in;
         on_len_ff    <= on_len_in;
         off_len_ff   <= off_len_in;
         phase_ff     <= phase_in;
         off_phase_ff <= off_phase_in;
         recompute_ff <= recompute_in;
         action_ff    <= action_in;
      end
   end

   // divider and result payload need no reset
   always_ff @(posedge clock) begin
      divisor_ff  <= divisor_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      led_ff      <= led_in;
      out_freq_ff <= out_freq_in;
      out_on_ff   <= out_on_in;
      out_off_ff  <= out_off_in;
   end

   assign rsp_led_on    = led_ff;
   assign rsp_frequency = out_freq_ff;
   assign rsp_on_ticks  = out_on_ff;
   assign rsp_off_ticks = out_off_ff;

endmodule

`default_nettype wire

@@ hw/rtl/etsg_ctrl.sv @@
// Controller: item sequencing, divider step count and result valid.
`default_nettype none

module etsg_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire etsg_pkg::status_type status,
   output etsg_pkg::cmd_type         cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type                  state_ff, state_in;
   logic [etsg_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // commands to the datapath
   always_comb begin
      cmd.accept   = (state_ff == ST_IDLE) && req_valid;
      cmd.div_step = (state_ff == ST_DIVIDE);
      cmd.finish   = (state_ff == ST_FINISH) && slot_free;
   end

   // next state
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = cmd.finish || (rsp_valid_ff && rsp_stall);
      case (state_ff)
         ST_IDLE: begin
            if (cmd.accept) begin
               cnt_in   = '0;
               state_in = status.recompute ? ST_DIVIDE : ST_FINISH;
            end
         end
         ST_DIVIDE: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == etsg_pkg::CNT_W'(etsg_pkg::DIV_STEPS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (cmd.finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold state, step count and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ hw/rtl/encoder_tuned_strobe_generator.sv @@
// Top level of the encoder-tuned strobe generator.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  action, enc_a, enc_b
//   rsp_      out        rsp_valid/rsp_stall  led_on, frequency, on_ticks, off_ticks
//   csr_      in         csr_wr_en            ticks_per_second (csr_wr_data)
//
// A tick, or an encoder sample whose step is refused, goes from accept straight to the
// finish state, which loads the result register once the result slot is free. Any other
// encoder sample (a step taken or no step, 0 Hz included) first runs the 16-step serial
// divider that works out the period, then finishes the same way. One item is in work at a
// time; the next one is accepted while the result register still waits on rsp_stall.
// Synchronous active-high reset; no clearing pass is needed after it.
`default_nettype none

module encoder_tuned_strobe_generator (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_action,
   input  wire logic                          req_enc_a,
   input  wire logic                          req_enc_b,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_led_on,
   output logic [etsg_pkg::FREQ_W-1:0]        rsp_frequency,
   output logic [etsg_pkg::ON_W-1:0]          rsp_on_ticks,
   output logic [etsg_pkg::PERIOD_W-1:0]      rsp_off_ticks,
   input  wire logic                          csr_wr_en,
   input  wire logic [etsg_pkg::TPS_W-1:0]    csr_wr_data
);

   etsg_pkg::cmd_type    cmd;
   etsg_pkg::status_type status;

   etsg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   etsg_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_action    (req_action),
      .req_enc_a     (req_enc_a),
      .req_enc_b     (req_enc_b),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .cmd           (cmd),
      .status        (status),
      .rsp_led_on    (rsp_led_on),
      .rsp_frequency (rsp_frequency),
      .rsp_on_ticks  (rsp_on_ticks),
      .rsp_off_ticks (rsp_off_ticks)
   );

   // checks on the sequencing and the result values
`include "encoder_tuned_strobe_generator_assert.svh"

   `ETSG_ASSERT_NOW(a_freq_max, clock, reset, rsp_valid,
      rsp_frequency <= etsg_pkg::MAX_FREQUENCY, "frequency above maximum")
   `ETSG_ASSERT_NOW(a_on_le_off, clock, reset, rsp_valid,
      {2'b00, rsp_on_ticks} <= rsp_off_ticks, "on length exceeds off length")
   `ETSG_ASSERT_NEXT(a_accept_busy, clock, reset, cmd.accept, req_stall,
      "controller did not leave idle after accept")
   `ETSG_ASSERT_NEXT(a_finish_valid, clock, reset, cmd.finish, rsp_valid && !req_stall,
      "finished item not presented")

endmodule

`default_nettype wire
